[design/mwmd_pkg.sv]
// Shared widths, reset values, register codes and the front-to-back word type.
package mwmd_pkg;

    localparam int VEL_W      = 16;
    localparam int CD_W       = 16;
    localparam int LIM_W      = 15;
    localparam int WHL_W      = 16;
    localparam int SUM_W      = 18;               // signed wheel mix before scaling
    localparam int MAG_W      = SUM_W - 1;        // magnitude of a wheel mix
    localparam int PROD_W     = MAG_W + LIM_W;    // magnitude times limit
    localparam int QUOT_W     = LIM_W;            // scaled magnitude never exceeds limit
    localparam int ROT_W      = 32;               // turn rate times center distance
    localparam int NUM_WHEELS = 4;
    localparam int CFG_IDX_W  = 1;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CD_W-1:0]  CD_RESET  = 16'd20000;
    localparam logic [LIM_W-1:0] LIM_RESET = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_DIST = 1'b0,
        REG_SPEED_LIMIT = 1'b1
    } t_cfg_reg;

    // Classified command handed from the mixer to the scaler.
    typedef struct packed {
        logic [NUM_WHEELS-1:0][WHL_W-1:0] wheel;   // unscaled result, low bits
        logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;     // |w|
        logic [NUM_WHEELS-1:0]            neg;     // sign of w
        logic [MAG_W-1:0]                 peak;    // largest |w|
        logic                             scaled;  // peak above limit
    } t_mix_word;

endpackage

[design/mwmd_vel_if.sv]
// Velocity command channel.
interface mwmd_vel_if;
    logic                                valid;
    logic                                ready;
    logic signed [mwmd_pkg::VEL_W-1:0]   vel_x;
    logic signed [mwmd_pkg::VEL_W-1:0]   vel_y;
    logic signed [mwmd_pkg::VEL_W-1:0]   vel_turn;

    modport source (output valid, output vel_x, output vel_y, output vel_turn, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input vel_turn, output ready);
endinterface

[design/mwmd_whl_if.sv]
// Wheel setpoint channel.
interface mwmd_whl_if;
    logic                                valid;
    logic                                ready;
    logic signed [mwmd_pkg::WHL_W-1:0]   wheel_a;
    logic signed [mwmd_pkg::WHL_W-1:0]   wheel_b;
    logic signed [mwmd_pkg::WHL_W-1:0]   wheel_c;
    logic signed [mwmd_pkg::WHL_W-1:0]   wheel_d;
    logic                                was_scaled;

    modport source (output valid, output wheel_a, output wheel_b, output wheel_c,
                    output wheel_d, output was_scaled, input ready);
    modport sink   (input valid, input wheel_a, input wheel_b, input wheel_c,
                    input wheel_d, input was_scaled, output ready);
endinterface

[design/mwmd_cfg_if.sv]
// Configuration write channel.
interface mwmd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mwmd_pkg::CFG_IDX_W-1:0]       index;
    logic [mwmd_pkg::CD_W-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/mwmd_front.sv]
// Front end: rotation product, wheel mix, magnitude peak and limit compare.
module mwmd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mwmd_pkg::VEL_W-1:0]   i_vel_x,
    input  logic signed [mwmd_pkg::VEL_W-1:0]   i_vel_y,
    input  logic signed [mwmd_pkg::VEL_W-1:0]   i_vel_turn,
    input  logic [mwmd_pkg::CD_W-1:0]           i_center_dist,
    input  logic [mwmd_pkg::LIM_W-1:0]          i_speed_limit,
    output logic                                o_valid,
    input  logic                                i_ready,
    output mwmd_pkg::t_mix_word                 o_word
);
    import mwmd_pkg::*;

    logic                       r_v1;
    logic signed [VEL_W-1:0]    r_x1;
    logic signed [VEL_W-1:0]    r_y1;
    logic signed [ROT_W-1:0]    r_prod1;
    logic                       r_v2;
    logic signed [SUM_W-1:0]    r_w2 [NUM_WHEELS];

    logic                       rdy1;
    logic                       rdy2;
    logic signed [ROT_W:0]      prod_full;
    logic signed [ROT_W-1:0]    prod_bias;
    logic signed [SUM_W-1:0]    sx;
    logic signed [SUM_W-1:0]    sy;
    logic signed [SUM_W-1:0]    srot;
    logic signed [SUM_W-1:0]    n_w2 [NUM_WHEELS];
    logic [MAG_W-1:0]           peak01;
    logic [MAG_W-1:0]           peak23;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;

    assign prod_full = i_vel_turn * $signed({1'b0, i_center_dist});

    // Truncate toward zero: bias negative products before the shift.
    assign prod_bias = r_prod1 + (r_prod1[ROT_W-1] ? 32'sd65535 : 32'sd0);
    assign srot      = SUM_W'($signed(prod_bias[ROT_W-1:16]));
    assign sx        = SUM_W'(r_x1);
    assign sy        = SUM_W'(r_y1);

    always_comb begin
        n_w2[0] =  sx - sy - srot;
        n_w2[1] = -sx - sy - srot;
        n_w2[2] =  sx + sy - srot;
        n_w2[3] = -sx + sy - srot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_x1    <= i_vel_x;
            r_y1    <= i_vel_y;
            r_prod1 <= prod_full[ROT_W-1:0];
        end
        if (rdy2) begin
            r_w2 <= n_w2;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            o_word.neg[i]   = r_w2[i][SUM_W-1];
            o_word.mag[i]   = r_w2[i][SUM_W-1] ? MAG_W'(-r_w2[i]) : r_w2[i][MAG_W-1:0];
            o_word.wheel[i] = r_w2[i][WHL_W-1:0];
        end
        peak01        = (o_word.mag[0] > o_word.mag[1]) ? o_word.mag[0] : o_word.mag[1];
        peak23        = (o_word.mag[2] > o_word.mag[3]) ? o_word.mag[2] : o_word.mag[3];
        o_word.peak   = (peak01 > peak23) ? peak01 : peak23;
        o_word.scaled = o_word.peak > MAG_W'(i_speed_limit);
    end

endmodule

[design/mwmd_queue.sv]
// Small register FIFO between the mixer and the scaler.
module mwmd_queue #(
    parameter int DEPTH = mwmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push_valid,
    output logic                    o_push_ready,
    input  mwmd_pkg::t_mix_word     i_push_word,
    output logic                    o_pop_valid,
    input  logic                    i_pop_ready,
    output mwmd_pkg::t_mix_word     o_pop_word
);
    import mwmd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_mix_word          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_word   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

endmodule

[design/mwmd_back.sv]
// Back end: |w|*limit, one quotient bit per stage, sign restore, output register.
module mwmd_back (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  mwmd_pkg::t_mix_word                         i_word,
    input  logic [mwmd_pkg::LIM_W-1:0]                  i_speed_limit,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [mwmd_pkg::NUM_WHEELS-1:0][mwmd_pkg::WHL_W-1:0] o_wheel,
    output logic                                        o_was_scaled
);
    import mwmd_pkg::*;

    localparam int NSTG = QUOT_W + 1;

    logic                                 r_v    [NSTG];
    logic [NUM_WHEELS-1:0][PROD_W-1:0]    r_rem  [NSTG];
    logic [NUM_WHEELS-1:0][QUOT_W-1:0]    r_quo  [NSTG];
    logic [MAG_W-1:0]                     r_div  [NSTG];
    logic [NUM_WHEELS-1:0]                r_neg  [NSTG];
    logic [NUM_WHEELS-1:0][WHL_W-1:0]     r_whl  [NSTG];
    logic                                 r_scl  [NSTG];

    logic                                 r_out_v;
    logic [NUM_WHEELS-1:0][WHL_W-1:0]     r_out_whl;
    logic                                 r_out_scl;

    logic                                 en;
    logic [NUM_WHEELS-1:0][WHL_W-1:0]     n_out_whl;
    logic [WHL_W-1:0]                     q16 [NUM_WHEELS];

    // Whole back end moves together; stalls only when the output word is held.
    assign en           = !r_out_v || i_ready;
    assign o_ready      = en;
    assign o_valid      = r_out_v;
    assign o_wheel      = r_out_whl;
    assign o_was_scaled = r_out_scl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_v <= r_v[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_rem[0][i] <= PROD_W'(i_word.mag[i]) * PROD_W'(i_speed_limit);
            end
            r_quo[0] <= '0;
            r_div[0] <= i_word.peak;
            r_neg[0] <= i_word.neg;
            r_whl[0] <= i_word.wheel;
            r_scl[0] <= i_word.scaled;
        end
    end

    for (genvar k = 1; k < NSTG; k++) begin : g_div
        localparam int BIT = QUOT_W - k;
        logic [PROD_W-1:0] trial;
        assign trial = PROD_W'(r_div[k-1]) << BIT;

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < NUM_WHEELS; i++) begin
                    if (r_rem[k-1][i] >= trial) begin
                        r_rem[k][i] <= r_rem[k-1][i] - trial;
                        r_quo[k][i] <= r_quo[k-1][i] | (QUOT_W'(1) << BIT);
                    end else begin
                        r_rem[k][i] <= r_rem[k-1][i];
                        r_quo[k][i] <= r_quo[k-1][i];
                    end
                end
                r_div[k] <= r_div[k-1];
                r_neg[k] <= r_neg[k-1];
                r_whl[k] <= r_whl[k-1];
                r_scl[k] <= r_scl[k-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            q16[i] = {1'b0, r_quo[NSTG-1][i]};
            if (r_scl[NSTG-1]) begin
                n_out_whl[i] = r_neg[NSTG-1][i] ? (~q16[i] + 1'b1) : q16[i];
            end else begin
                n_out_whl[i] = r_whl[NSTG-1][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_whl <= n_out_whl;
            r_out_scl <= r_scl[NSTG-1];
        end
    end

endmodule

[design/mecanum_wheel_mix_desaturate.sv]
// Mecanum wheel mixer with proportional desaturation: top level.
// Path from command accept to result valid with an empty queue: 2 mixer stages,
//   queue write/read, multiply stage, 15 divider stages (the bulk), output reg.
// Throughput: one command per cycle unless the wheel output stalls.
// Reset: synchronous active low; clears all valid flags and queue pointers and
//   loads center distance 20000 and wheel speed limit 16384.
module mecanum_wheel_mix_desaturate #(
    parameter int QUEUE_DEPTH = mwmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mwmd_vel_if.sink        i_vel,
    mwmd_whl_if.source      o_whl,
    mwmd_cfg_if.sink        i_cfg
);
    import mwmd_pkg::*;

    // Configuration registers: user writes only with datapath idle (not enforced).
    logic [CD_W-1:0]    r_center_dist;
    logic [LIM_W-1:0]   r_speed_limit;

    // Mixer to queue
    logic               mix_valid;
    logic               mix_ready;
    t_mix_word          mix_word;

    // Queue to scaler
    logic               que_valid;
    logic               que_ready;
    t_mix_word          que_word;

    logic [NUM_WHEELS-1:0][WHL_W-1:0] wheel;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_dist <= CD_RESET;
            r_speed_limit <= LIM_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_CENTER_DIST: r_center_dist <= i_cfg.data;
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg.data[LIM_W-1:0];
            endcase
        end
    end

    // Front: rotation term, four-wheel mix, peak magnitude and limit check.
    mwmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_vel.valid),
        .o_ready       (i_vel.ready),
        .i_vel_x       (i_vel.vel_x),
        .i_vel_y       (i_vel.vel_y),
        .i_vel_turn    (i_vel.vel_turn),
        .i_center_dist (r_center_dist),
        .i_speed_limit (r_speed_limit),
        .o_valid       (mix_valid),
        .i_ready       (mix_ready),
        .o_word        (mix_word)
    );

    // Decoupling queue: absorbs back-end stalls so the front keeps taking words.
    mwmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (mix_valid),
        .o_push_ready (mix_ready),
        .i_push_word  (mix_word),
        .o_pop_valid  (que_valid),
        .i_pop_ready  (que_ready),
        .o_pop_word   (que_word)
    );

    // Back: w * limit / peak for all four wheels when the peak exceeds the limit.
    mwmd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (que_valid),
        .o_ready       (que_ready),
        .i_word        (que_word),
        .i_speed_limit (r_speed_limit),
        .o_valid       (o_whl.valid),
        .i_ready       (o_whl.ready),
        .o_wheel       (wheel),
        .o_was_scaled  (o_whl.was_scaled)
    );

    assign o_whl.wheel_a = wheel[0];
    assign o_whl.wheel_b = wheel[1];
    assign o_whl.wheel_c = wheel[2];
    assign o_whl.wheel_d = wheel[3];

endmodule

[design/mwmd_chk.sv]
// Port-level checker for the wheel mixer, bound to the top level.
module mwmd_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [mwmd_pkg::WHL_W-1:0]  i_wheel_a,
    input logic signed [mwmd_pkg::WHL_W-1:0]  i_wheel_b,
    input logic signed [mwmd_pkg::WHL_W-1:0]  i_wheel_c,
    input logic signed [mwmd_pkg::WHL_W-1:0]  i_wheel_d,
    input logic                               i_was_scaled
);
    import mwmd_pkg::*;

    localparam logic [WHL_W-1:0] MOST_NEG = {1'b1, {(WHL_W-1){1'b0}}};

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_wheel_a) && $stable(i_wheel_b) &&
            $stable(i_wheel_c) && $stable(i_wheel_d) && $stable(i_was_scaled))
        else $error("result word changed while stalled");

    a_no_most_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_wheel_a != MOST_NEG && i_wheel_b != MOST_NEG &&
            i_wheel_c != MOST_NEG && i_wheel_d != MOST_NEG)
        else $error("wheel setpoint outside the limit range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind mecanum_wheel_mix_desaturate mwmd_chk u_mwmd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_whl.valid),
    .i_out_ready  (o_whl.ready),
    .i_wheel_a    (o_whl.wheel_a),
    .i_wheel_b    (o_whl.wheel_b),
    .i_wheel_c    (o_whl.wheel_c),
    .i_wheel_d    (o_whl.wheel_d),
    .i_was_scaled (o_whl.was_scaled)
);

[tb/sv/tb.sv]
// Testbench for the mecanum wheel mixer: directed and random commands checked by a scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwmd_pkg::*;

    // A whole run has no legal gap longer than the pipeline latency plus
    // the longest run of random stalls.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last result.
    localparam int DRAIN_TAIL     = 40;
    localparam int PHASE_ITEMS    = 175;
    localparam int NUM_PHASES     = 8;

    // One wheel setpoint word as seen on the output channel.
    typedef struct packed {
        logic signed [WHL_W-1:0] wheel_a;
        logic signed [WHL_W-1:0] wheel_b;
        logic signed [WHL_W-1:0] wheel_c;
        logic signed [WHL_W-1:0] wheel_d;
        logic                    was_scaled;
    } t_wheel_set;

    // Scoreboard: a private copy of both registers and a queue of expected setpoints.
    class wheel_scoreboard;
        logic [CD_W-1:0]  center_dist;
        logic [LIM_W-1:0] speed_limit;
        t_wheel_set       setpoint_q[$];
        int               errors;

        function new();
            center_dist = CD_RESET;
            speed_limit = LIM_RESET;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CD_W-1:0] d);
            case (idx)
                REG_CENTER_DIST: center_dist = d;
                REG_SPEED_LIMIT: speed_limit = d[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Mix one velocity command into four wheels and desaturate the result.
        function void note_cmd(logic signed [VEL_W-1:0] vx, logic signed [VEL_W-1:0] vy,
                               logic signed [VEL_W-1:0] vt);
            longint     rot;
            longint     peak;
            longint     mag;
            longint     lim;
            longint     w[NUM_WHEELS];
            t_wheel_set e;
            // Signed division truncates toward zero, as the rotation term requires.
            rot  = (longint'(vt) * longint'(center_dist)) / 65536;
            w[0] =  longint'(vx) - longint'(vy) - rot;
            w[1] = -longint'(vx) - longint'(vy) - rot;
            w[2] =  longint'(vx) + longint'(vy) - rot;
            w[3] = -longint'(vx) + longint'(vy) - rot;
            lim  = longint'(speed_limit);
            peak = 0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                mag = (w[i] < 0) ? -w[i] : w[i];
                if (mag > peak) begin
                    peak = mag;
                end
            end
            e.was_scaled = (peak > lim);
            if (e.was_scaled) begin
                for (int i = 0; i < NUM_WHEELS; i++) begin
                    w[i] = (w[i] * lim) / peak;
                end
            end
            e.wheel_a = w[0][WHL_W-1:0];
            e.wheel_b = w[1][WHL_W-1:0];
            e.wheel_c = w[2][WHL_W-1:0];
            e.wheel_d = w[3][WHL_W-1:0];
            setpoint_q.push_back(e);
        endfunction

        function void compare_field(string name, logic signed [WHL_W:0] exp_v,
                                    logic signed [WHL_W:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_wheels(t_wheel_set got);
            t_wheel_set e;
            if (setpoint_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected wheel word, expected none, got %h", $time, got);
                return;
            end
            e = setpoint_q.pop_front();
            compare_field("wheel_a", e.wheel_a, got.wheel_a);
            compare_field("wheel_b", e.wheel_b, got.wheel_b);
            compare_field("wheel_c", e.wheel_c, got.wheel_c);
            compare_field("wheel_d", e.wheel_d, got.wheel_d);
            compare_field("was_scaled", e.was_scaled, got.was_scaled);
        endfunction

        function int pending();
            return setpoint_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mwmd_vel_if vel_ch ();
    mwmd_whl_if whl_ch ();
    mwmd_cfg_if cfg_ch ();

    mecanum_wheel_mix_desaturate dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vel   (vel_ch),
        .o_whl   (whl_ch),
        .i_cfg   (cfg_ch)
    );

    wheel_scoreboard sb;

    // Idle odds in percent, changed per phase by the stimulus process.
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: ready is re-rolled at every falling edge.
    always @(negedge i_clk) begin
        whl_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: every handshake is taken at the rising edge, before the block's
    // registers update.  Commands are predicted at acceptance with the
    // register values in force at that moment; registers only change while
    // nothing is in flight.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (vel_ch.valid && vel_ch.ready) begin
                sb.note_cmd(vel_ch.vel_x, vel_ch.vel_y, vel_ch.vel_turn);
            end
            if (whl_ch.valid && whl_ch.ready) begin
                sb.check_wheels({whl_ch.wheel_a, whl_ch.wheel_b, whl_ch.wheel_c,
                                 whl_ch.wheel_d, whl_ch.was_scaled});
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.set_reg(t_cfg_reg'(cfg_ch.index), cfg_ch.data);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((vel_ch.valid && vel_ch.ready) || (whl_ch.valid && whl_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d words outstanding", $time, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Present one command word.  The task is entered and left at a falling
    // edge.  On an idle gap valid drops at this edge and rises at a later
    // one, so valid is never lowered and raised in one time step.  Without a
    // gap valid simply stays high.
    task automatic send_cmd(input logic signed [VEL_W-1:0] vx,
                            input logic signed [VEL_W-1:0] vy,
                            input logic signed [VEL_W-1:0] vt);
        if ($urandom_range(99) < send_idle_pct) begin
            vel_ch.valid <= 1'b0;
            do begin
                @(negedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        vel_ch.valid    <= 1'b1;
        vel_ch.vel_x    <= vx;
        vel_ch.vel_y    <= vy;
        vel_ch.vel_turn <= vt;
        do begin
            @(posedge i_clk);
        end while (!vel_ch.ready);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic wait_all_results();
        vel_ch.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // A single register write.  Called only when the pipeline is empty.
    // Valid drops at a falling edge and the task returns only at a later
    // one, so a following write raises it again at a later edge.
    task automatic cfg_write(input t_cfg_reg idx, input logic [CD_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Both registers.  Bit 15 of the limit word is random, because only
    // its low 15 bits are stored.
    task automatic load_regs(input logic [CD_W-1:0] cd, input logic [LIM_W-1:0] lim);
        wait_all_results();
        cfg_write(REG_CENTER_DIST, cd);
        cfg_write(REG_SPEED_LIMIT, {1'($urandom_range(1)), lim});
    endtask

    // Random velocity.  Values are a blend of full-range patterns, which
    // mostly saturate, and small ones near the limit, which mostly pass.
    // A few are picked from the edge values.
    function automatic logic signed [VEL_W-1:0] rand_vel(input int lim);
        int sel;
        int span;
        sel  = $urandom_range(9);
        span = (lim < 2) ? 2 : lim / 2;
        if (sel < 4) begin
            return VEL_W'($urandom);
        end else if (sel < 8) begin
            return VEL_W'($urandom_range(2 * span) - span);
        end else begin
            case ($urandom_range(4))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return 16'sh0000;
                3:       return -16'sd1;
                default: return 16'sd1;
            endcase
        end
    endfunction

    initial begin
        int lim_now;
        int mode;
        logic [CD_W-1:0]  cd_sel;
        logic [LIM_W-1:0] lim_sel;

        sb              = new();
        quiet_cycles    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        vel_ch.valid    = 1'b0;
        vel_ch.vel_x    = '0;
        vel_ch.vel_y    = '0;
        vel_ch.vel_turn = '0;
        whl_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_CENTER_DIST;
        cfg_ch.data     = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, first with the reset registers.
        send_cmd(16'sd0, 16'sd0, 16'sd0);                  // all wheels zero, no division
        send_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
        send_cmd(16'sh7fff, 16'sh8000, 16'sd0);
        send_cmd(16'sh8000, 16'sh7fff, 16'sh8000);
        send_cmd(16'sd16384, 16'sd0, 16'sd0);              // peak equals limit, passes
        send_cmd(16'sd16385, 16'sd0, 16'sd0);              // one above limit, scales
        send_cmd(16'sd0, 16'sd0, 16'sd1);                  // rotation term truncates to zero
        send_cmd(16'sd0, 16'sd0, -16'sd1);                 // negative truncation toward zero
        send_cmd(16'sd1, -16'sd1, 16'sd0);

        // Largest distance, smallest limit.
        load_regs(16'hffff, 15'd1);
        send_cmd(16'sd1, 16'sd0, 16'sd0);                  // peak 1 equals limit
        send_cmd(16'sd2, 16'sd0, 16'sd0);
        send_cmd(16'sh7fff, 16'sh7fff, 16'sh8000);
        send_cmd(16'sh8000, 16'sh8000, 16'sh7fff);
        send_cmd(16'sd0, 16'sd0, 16'sh8000);
        send_cmd(16'sd3, 16'sd1, 16'sd0);                  // quotients truncate unevenly

        // No rotation lever, largest limit.
        load_regs(16'h0000, 15'd32767);
        send_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_cmd(16'sh8000, 16'sh7fff, 16'sd5);
        send_cmd(16'sd16383, 16'sd16384, 16'sd0);          // peak exactly 32767
        send_cmd(16'sh8000, 16'sd0, 16'sd0);               // peak 32768, just over

        // Random phases.  Each phase has its own registers and idle mode.
        // The modes rotate through no idling, a sparse sender, a stalling
        // receiver, and light idling on both sides.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    cd_sel  = 16'hffff;
                    lim_sel = 15'd32767;
                end
                1: begin
                    cd_sel  = 16'h0000;
                    lim_sel = 15'd1;
                end
                2: begin
                    cd_sel  = CD_RESET;
                    lim_sel = LIM_RESET;
                end
                default: begin
                    cd_sel  = CD_W'($urandom);
                    lim_sel = LIM_W'($urandom_range(32767, 1));
                end
            endcase
            // Registers change only with the block idle, so the idle odds
            // are cleared first to let the last phase drain quickly.
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            load_regs(cd_sel, lim_sel);
            lim_now = lim_sel;

            mode = ph % 4;
            send_idle_pct  = (mode == 1) ? 88 : (mode == 3) ? 14 : 0;
            recv_stall_pct = (mode == 2) ? 88 : (mode == 3) ? 14 : 0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once in the run the sender holds off until the pipeline is
                // empty, then it resumes in the middle of the phase.
                if (ph == 5 && n == 80) begin
                    wait_all_results();
                end
                send_cmd(rand_vel(lim_now), rand_vel(lim_now), rand_vel(lim_now));
            end
        end

        // Wrap-up: drain the pipeline, give the block DRAIN_TAIL quiet cycles
        // to expose any stray word, then report.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_all_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected wheel words never arrived", $time, sb.pending());
        end
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
